>>> rtl/cnpt_pkg.sv
`default_nettype none

package cnpt_pkg;

  // Table geometry
  localparam int unsigned MaxPoints = 1024;
  localparam int unsigned CoordBits = 10;
  localparam int unsigned SlotBits  = $clog2(MaxPoints);
  localparam int unsigned CountBits = $clog2(MaxPoints + 1);

  // Port field widths
  localparam int unsigned CoordFieldBits = 10;
  localparam int unsigned SlotFieldBits  = 10;
  localparam int unsigned DistFieldBits  = 10;

  // Request codes
  localparam logic ReqInsert = 1'b0;
  localparam logic ReqQuery  = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusEmpty = 2'd1,
    StatusFull  = 2'd2
  } status_e;

  typedef logic [CoordBits-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  // Controller to datapath
  typedef struct packed {
    logic cap;       // capture request, restart scan
    logic scan_rd;   // read next slot into the scan pipeline
    logic ins;       // write captured point at the next free slot
    logic out_load;  // load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_query;   // incoming request is a query
    logic is_query;   // captured request is a query
    logic empty;      // no point stored
    logic full;       // table full
    logic scan_last;  // scan address is the last stored slot
    logic pipe_busy;  // scan pipeline still holds a point
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/cnpt_if.sv
`default_nettype none

// Request channel
interface cnpt_req_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic [cnpt_pkg::CoordFieldBits-1:0] x_coord;
  logic [cnpt_pkg::CoordFieldBits-1:0] y_coord;
  logic [cnpt_pkg::CoordFieldBits-1:0] z_coord;

  modport source (output valid, req_type, x_coord, y_coord, z_coord, input ready);
  modport sink   (input valid, req_type, x_coord, y_coord, z_coord, output ready);
endinterface

// Response channel
interface cnpt_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         status;
  logic [cnpt_pkg::SlotFieldBits-1:0] slot_index;
  logic [cnpt_pkg::DistFieldBits-1:0] nearest_distance;

  modport source (output valid, status, slot_index, nearest_distance, input ready);
  modport sink   (input valid, status, slot_index, nearest_distance, output ready);
endinterface

`default_nettype wire

>>> rtl/cnpt_dp.sv
`default_nettype none

module cnpt_dp (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 req_type_i,
  input  wire [cnpt_pkg::CoordFieldBits-1:0]  x_coord_i,
  input  wire [cnpt_pkg::CoordFieldBits-1:0]  y_coord_i,
  input  wire [cnpt_pkg::CoordFieldBits-1:0]  z_coord_i,
  input  cnpt_pkg::cmd_t                      cmd_i,
  output cnpt_pkg::sts_t                      sts_o,
  output logic [1:0]                          status_o,
  output logic [cnpt_pkg::SlotFieldBits-1:0]  slot_index_o,
  output logic [cnpt_pkg::DistFieldBits-1:0]  nearest_distance_o
);

  function automatic cnpt_pkg::coord_t axis_gap(cnpt_pkg::coord_t a, cnpt_pkg::coord_t b);
    axis_gap = (a > b) ? (a - b) : (b - a);
  endfunction

  cnpt_pkg::point_t mem_q [cnpt_pkg::MaxPoints];

  logic                              type_q;
  cnpt_pkg::point_t                  pt_q;
  logic [cnpt_pkg::CountBits-1:0]    count_q, count_d;
  logic [cnpt_pkg::CountBits-1:0]    addr_q, addr_d;
  logic                              full;

  // Scan pipeline: read, distance, compare
  logic                              rd_vld_q;
  logic [cnpt_pkg::SlotBits-1:0]     rd_idx_q;
  cnpt_pkg::point_t                  rd_pt_q;
  logic                              dist_vld_q;
  logic [cnpt_pkg::SlotBits-1:0]     dist_idx_q;
  cnpt_pkg::coord_t                  dist_q, dist_d;
  logic                              best_vld_q;
  logic [cnpt_pkg::SlotBits-1:0]     best_idx_q;
  cnpt_pkg::coord_t                  best_q;
  cnpt_pkg::coord_t                  gx, gy, gz, gxy;

  logic [1:0]                        res_status;
  logic [cnpt_pkg::SlotFieldBits-1:0] res_slot;
  logic [cnpt_pkg::DistFieldBits-1:0] res_dist;

  assign full = (count_q == cnpt_pkg::CountBits'(cnpt_pkg::MaxPoints));

  // Capture the request payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      type_q <= req_type_i;
      pt_q.x <= cnpt_pkg::CoordBits'(x_coord_i);
      pt_q.y <= cnpt_pkg::CoordBits'(y_coord_i);
      pt_q.z <= cnpt_pkg::CoordBits'(z_coord_i);
    end
  end

  // Point memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins) begin
      mem_q[count_q[cnpt_pkg::SlotBits-1:0]] <= pt_q;
    end
    if (cmd_i.scan_rd) begin
      rd_pt_q  <= mem_q[addr_q[cnpt_pkg::SlotBits-1:0]];
      rd_idx_q <= addr_q[cnpt_pkg::SlotBits-1:0];
    end
  end

  // Fill count and scan address
  always_comb begin
    count_d = count_q;
    if (cmd_i.ins) begin
      count_d = count_q + cnpt_pkg::CountBits'(1);
    end
    addr_d = addr_q;
    if (cmd_i.cap) begin
      addr_d = '0;
    end else if (cmd_i.scan_rd) begin
      addr_d = addr_q + cnpt_pkg::CountBits'(1);
    end
  end

  // Chebyshev distance of the point just read
  always_comb begin
    gx  = axis_gap(pt_q.x, rd_pt_q.x);
    gy  = axis_gap(pt_q.y, rd_pt_q.y);
    gz  = axis_gap(pt_q.z, rd_pt_q.z);
    gxy = (gy > gx) ? gy : gx;
    dist_d = (gz > gxy) ? gz : gxy;
  end

  // Control state of the scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      addr_q     <= '0;
      rd_vld_q   <= 1'b0;
      dist_vld_q <= 1'b0;
      best_vld_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      addr_q     <= addr_d;
      rd_vld_q   <= cmd_i.scan_rd;
      dist_vld_q <= rd_vld_q;
      if (cmd_i.cap) begin
        best_vld_q <= 1'b0;
      end else if (dist_vld_q) begin
        best_vld_q <= 1'b1;
      end
    end
  end

  // Distance stage and running minimum; strict compare keeps the lowest slot
  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      dist_q     <= dist_d;
      dist_idx_q <= rd_idx_q;
    end
    if (dist_vld_q && (!best_vld_q || (dist_q < best_q))) begin
      best_q     <= dist_q;
      best_idx_q <= dist_idx_q;
    end
  end

  // Select the result
  always_comb begin
    res_status = cnpt_pkg::StatusOk;
    res_slot   = '0;
    res_dist   = '0;
    if (type_q == cnpt_pkg::ReqInsert) begin
      if (full) begin
        res_status = cnpt_pkg::StatusFull;
      end else begin
        res_slot = cnpt_pkg::SlotFieldBits'(count_q);
      end
    end else begin
      if (count_q == '0) begin
        res_status = cnpt_pkg::StatusEmpty;
      end else begin
        res_slot = cnpt_pkg::SlotFieldBits'(best_idx_q);
        res_dist = cnpt_pkg::DistFieldBits'(best_q);
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_o           <= res_status;
      slot_index_o       <= res_slot;
      nearest_distance_o <= res_dist;
    end
  end

  always_comb begin
    sts_o.in_query  = (req_type_i == cnpt_pkg::ReqQuery);
    sts_o.is_query  = (type_q == cnpt_pkg::ReqQuery);
    sts_o.empty     = (count_q == '0);
    sts_o.full      = full;
    sts_o.scan_last = ((addr_q + cnpt_pkg::CountBits'(1)) == count_q);
    sts_o.pipe_busy = rd_vld_q | dist_vld_q;
  end

endmodule

`default_nettype wire

>>> rtl/cnpt_ctrl.sv
`default_nettype none

module cnpt_ctrl (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire             out_ready_i,
  input  cnpt_pkg::sts_t  sts_i,
  output cnpt_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StScan  = 4'b0010,
    StDrain = 4'b0100,
    StFin   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_fire, out_free;

  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // Sequence one transaction at a time
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.cap     = in_fire;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d = (sts_i.in_query && !sts_i.empty) ? StScan : StFin;
        end
      end
      StScan: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (!sts_i.pipe_busy) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.ins      = !sts_i.is_query && !sts_i.full;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Hold the result until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/chebyshev_nearest_point_table.sv
// Insert or empty query: the request is captured, then the result register is
// loaded once the output is free. Query on N stored points: the scan reads one
// point per cycle from the single memory port through the read, distance and
// compare stages before the result is loaded. A new request is taken only while
// idle; a result still waiting stalls the next one in its final state.
// Reset clears the point count and handshake state; memory contents are kept.
`default_nettype none

module chebyshev_nearest_point_table (
  input  wire         clk_i,
  input  wire         rst_ni,
  cnpt_req_if.sink    req_i,
  cnpt_rsp_if.source  rsp_o
);

  cnpt_pkg::cmd_t cmd;
  cnpt_pkg::sts_t sts;

  cnpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cnpt_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .req_type_i         (req_i.req_type),
    .x_coord_i          (req_i.x_coord),
    .y_coord_i          (req_i.y_coord),
    .z_coord_i          (req_i.z_coord),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .status_o           (rsp_o.status),
    .slot_index_o       (rsp_o.slot_index),
    .nearest_distance_o (rsp_o.nearest_distance)
  );

endmodule

`default_nettype wire
